[rtl/core/glb_pkg.sv]
// shared types, constants and kernel weights for the 5x5 gaussian blur
`timescale 1ns / 1ps
package glb_pkg;

  // default sizes handed to the top level
  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_MAX_HEIGHT     = 4096;
  localparam int DEF_COEF_FRAC_BITS = 16;

  // fixed kernel scale of the base weight table
  localparam int BASE_FRAC = 16;

  // pixel and field widths
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int TAPS      = 5;
  localparam int LINES     = TAPS - 1;
  localparam int LINE_W    = LINES * PIX_W;
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 10;
  localparam int WCFG_W    = 11;
  localparam int HCFG_W    = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // weight classes by distance from the center, sums of up to eight pixels
  localparam int NUM_CLS = 6;
  localparam int SUM_W   = CH_W + 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [NUM_CLS-1:0][SUM_W-1:0] cls_sums_t;

  // one window reduced to class sums, plus the result position
  typedef struct packed {
    cls_sums_t              red;
    cls_sums_t              green;
    cls_sums_t              blue;
    logic [ROW_OUT_W-1:0]   center_row;
    logic [COL_OUT_W-1:0]   center_col;
    logic                   frame_done;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } queue_stat_t;

  // base Q0.16 weight of each class
  function automatic logic [31:0] base_weight(input int k);
    logic [31:0] w;
    case (k)
      0:       w = 32'd10624;
      1:       w = 32'd6443;
      2:       w = 32'd1438;
      3:       w = 32'd3908;
      4:       w = 32'd872;
      5:       w = 32'd195;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

  // class weight at the chosen fraction, rounded half up when narrower
  function automatic logic [63:0] class_weight(input int k, input int frac);
    logic [63:0] t;
    int sh;
    t = 64'(base_weight(k));
    if (frac >= BASE_FRAC) begin
      sh = frac - BASE_FRAC;
      return t << sh;
    end
    sh = BASE_FRAC - frac;
    return (t + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // class of window tap (i, j): sorted distance pair
  function automatic int class_of(input int i, input int j);
    int ay;
    int ax;
    int lo;
    int hi;
    ay = (i >= 2) ? i - 2 : 2 - i;
    ax = (j >= 2) ? j - 2 : 2 - j;
    lo = (ay < ax) ? ay : ax;
    hi = (ay < ax) ? ax : ay;
    if (lo == 0) return hi;
    if (lo == 1) return 2 + hi;
    return 5;
  endfunction

endpackage

[rtl/core/glb_if.sv]
// pixel and result stream interfaces
`timescale 1ns / 1ps
interface glb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface glb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [11:0] center_row;
  logic [9:0]  center_col;
  logic        frame_done;

  modport source (output valid, red_out, green_out, blue_out, center_row, center_col,
                  frame_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, center_row, center_col,
                  frame_done, output ready);
endinterface

[rtl/core/glb_front.sv]
// front end: position tracking, line buffers, window and class sums
`timescale 1ns / 1ps
module glb_front import glb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  glb_in_if.sink               in_pix,
  input  queue_stat_t          qstat,
  output logic                 push,
  output job_t                 push_job,
  output logic                 clearing
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WV_W  = $clog2(MAX_WIDTH + 1);
  localparam int HV_W  = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [WCFG_W-1:0] width_cfg_r;
  logic [HCFG_W-1:0] height_cfg_r;
  logic [WV_W-1:0]   w_eff;
  logic [HV_W-1:0]   h_eff;

  // position
  logic [COL_W-1:0] col_r, col_nxt, cur_c;
  logic [ROW_W-1:0] row_r, row_nxt, cur_r;
  logic [COL_W:0]   c_a, c_n;
  logic [ROW_W:0]   r_a, r_n;
  logic             produce, done, accept;
  logic [ROW_OUT_W-1:0] crow;
  logic [COL_OUT_W-1:0] ccol;

  // line memory and clearing pass
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q_r, rd_eff, wb_data, mem_wdata;
  logic [COL_W-1:0]  clr_addr_r, mem_waddr;
  logic              clearing_r, mem_we;
  logic              byp_r;
  logic [LINE_W-1:0] byp_data_r;

  // stage after the read
  logic                 s1_v_r, s1_prod_r, s1_done_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [ROW_OUT_W-1:0] s1_row_o_r;
  logic [COL_OUT_W-1:0] s1_col_o_r;

  // stage that reads the window
  logic                 s2_v_r, s2_done_r;
  logic [ROW_OUT_W-1:0] s2_row_o_r;
  logic [COL_OUT_W-1:0] s2_col_o_r;

  logic [PIX_W-1:0] win_r [TAPS][TAPS];
  logic [PIX_W-1:0] col_px [TAPS];
  cls_sums_t        red_s, green_s, blue_s;

  // clamp the frame size
  always_comb begin
    if (32'(width_cfg_r) < 32'd5)              w_eff = WV_W'(5);
    else if (32'(width_cfg_r) > 32'(MAX_WIDTH)) w_eff = WV_W'(MAX_WIDTH);
    else                                         w_eff = WV_W'(width_cfg_r);
    if (32'(height_cfg_r) < 32'd5)               h_eff = HV_W'(5);
    else if (32'(height_cfg_r) > 32'(MAX_HEIGHT)) h_eff = HV_W'(MAX_HEIGHT);
    else                                           h_eff = HV_W'(height_cfg_r);
  end

  // position of this beat and of the next one
  always_comb begin
    c_a = in_pix.frame_start ? '0 : {1'b0, col_r};
    r_a = in_pix.frame_start ? '0 : {1'b0, row_r};
    if (32'(c_a) >= 32'(w_eff)) begin
      c_a = '0;
      r_a = r_a + 1'b1;
    end
    if (32'(r_a) >= 32'(h_eff)) r_a = '0;
    cur_c = c_a[COL_W-1:0];
    cur_r = r_a[ROW_W-1:0];

    c_n = {1'b0, cur_c} + 1'b1;
    r_n = {1'b0, cur_r} + 1'b1;
    if (32'(c_n) >= 32'(w_eff)) begin
      col_nxt = '0;
      row_nxt = (32'(r_n) >= 32'(h_eff)) ? '0 : r_n[ROW_W-1:0];
    end else begin
      col_nxt = c_n[COL_W-1:0];
      row_nxt = cur_r;
    end

    produce = (32'(cur_r) >= 32'd4) && (32'(cur_c) >= 32'd4);
    done    = (32'(cur_r) == 32'(h_eff) - 32'd1) && (32'(cur_c) == 32'(w_eff) - 32'd1);
    crow    = ROW_OUT_W'(32'(cur_r) - 32'd2);
    ccol    = COL_OUT_W'(32'(cur_c) - 32'd2);
  end

  // room in the queue for everything still in flight
  assign in_pix.ready = !clearing_r &&
                        (32'(qstat.count) + 32'(s1_v_r && s1_prod_r) + 32'(s2_v_r)
                         < 32'(QUEUE_DEPTH));
  assign accept   = in_pix.valid && in_pix.ready;
  assign clearing = clearing_r;

  // column read back, with forwarding of a write to the same column
  assign rd_eff  = byp_r ? byp_data_r : rd_q_r;
  assign wb_data = {rd_eff[LINE_W-PIX_W-1:0], s1_pix_r};

  assign mem_we    = clearing_r || s1_v_r;
  assign mem_waddr = clearing_r ? clr_addr_r : s1_col_r;
  assign mem_wdata = clearing_r ? '0 : wb_data;

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    if (accept) rd_q_r <= line_mem[cur_c];
  end

  // column of five, oldest row first
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      col_px[i] = rd_eff[(LINES-i)*PIX_W-1 -: PIX_W];
    end
    col_px[TAPS-1] = s1_pix_r;
  end

  // window shifts left one column per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS; j++) win_r[i][j] <= '0;
      end
    end else if (s1_v_r) begin
      for (int i = 0; i < TAPS; i++) begin
        for (int j = 0; j < TAPS-1; j++) win_r[i][j] <= win_r[i][j+1];
        win_r[i][TAPS-1] <= col_px[i];
      end
    end
  end

  // sums of the pixels that share a weight
  always_comb begin
    red_s   = '0;
    green_s = '0;
    blue_s  = '0;
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        red_s[class_of(i, j)]   = red_s[class_of(i, j)]   + SUM_W'(win_r[i][j][23:16]);
        green_s[class_of(i, j)] = green_s[class_of(i, j)] + SUM_W'(win_r[i][j][15:8]);
        blue_s[class_of(i, j)]  = blue_s[class_of(i, j)]  + SUM_W'(win_r[i][j][7:0]);
      end
    end
  end

  assign push                = s2_v_r;
  assign push_job.red        = red_s;
  assign push_job.green      = green_s;
  assign push_job.blue       = blue_s;
  assign push_job.center_row = s2_row_o_r;
  assign push_job.center_col = s2_col_o_r;
  assign push_job.frame_done = s2_done_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WCFG_W'(640);
      height_cfg_r <= HCFG_W'(480);
      col_r        <= '0;
      row_r        <= '0;
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      byp_r        <= 1'b0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_IMAGE_WIDTH:  width_cfg_r  <= cfg_wdata[WCFG_W-1:0];
          CFG_IMAGE_HEIGHT: height_cfg_r <= cfg_wdata[HCFG_W-1:0];
          default: ;
        endcase
      end
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clearing_r <= 1'b0;
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        byp_r <= s1_v_r && (s1_col_r == cur_c);
      end
      s1_v_r <= accept;
      s2_v_r <= s1_v_r && s1_prod_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data_r <= wb_data;
      s1_col_r   <= cur_c;
      s1_pix_r   <= {in_pix.red_in, in_pix.green_in, in_pix.blue_in};
      s1_prod_r  <= produce;
      s1_done_r  <= done;
      s1_row_o_r <= crow;
      s1_col_o_r <= ccol;
    end
    s2_done_r  <= s1_done_r;
    s2_row_o_r <= s1_row_o_r;
    s2_col_o_r <= s1_col_o_r;
  end

endmodule

[rtl/core/glb_fifo.sv]
// short queue of reduced windows between front and back
`timescale 1ns / 1ps
module glb_fifo import glb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        pop_job,
  output queue_stat_t stat
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign pop_job    = mem_r[rd_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/core/glb_back.sv]
// back end: weight multiply, accumulate, truncate, saturate and output register
`timescale 1ns / 1ps
module glb_back import glb_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_stat_t qstat,
  input  job_t        head,
  output logic        pop,
  glb_out_if.source   out_res
);

  localparam int WGT_W  = (COEF_FRAC_BITS >= BASE_FRAC) ? COEF_FRAC_BITS : BASE_FRAC;
  localparam int PROD_W = WGT_W + SUM_W;
  localparam int ACC_W  = PROD_W + 3;

  typedef logic [NUM_CLS-1:0][PROD_W-1:0] prods_t;

  prods_t               pr_r, pg_r, pb_r;
  prods_t               pr_nxt, pg_nxt, pb_nxt;
  logic                 b1_v_r, out_v_r, adv1, adv2;
  logic [ROW_OUT_W-1:0] b1_row_r;
  logic [COL_OUT_W-1:0] b1_col_r;
  logic                 b1_done_r;
  logic [ACC_W-1:0]     acc_r, acc_g, acc_b;
  logic [CH_W-1:0]      sat_r, sat_g, sat_b;
  logic [CH_W-1:0]      red_r, green_r, blue_r;
  logic [ROW_OUT_W-1:0] row_r;
  logic [COL_OUT_W-1:0] col_r;
  logic                 done_r;

  assign adv2 = !out_v_r || out_res.ready;
  assign adv1 = !b1_v_r || adv2;
  assign pop  = !qstat.empty && adv1;

  // products with the fixed class weights
  always_comb begin
    for (int k = 0; k < NUM_CLS; k++) begin
      pr_nxt[k] = PROD_W'(head.red[k])   * PROD_W'(class_weight(k, COEF_FRAC_BITS));
      pg_nxt[k] = PROD_W'(head.green[k]) * PROD_W'(class_weight(k, COEF_FRAC_BITS));
      pb_nxt[k] = PROD_W'(head.blue[k])  * PROD_W'(class_weight(k, COEF_FRAC_BITS));
    end
  end

  // sum, drop the fraction, saturate
  always_comb begin
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (int k = 0; k < NUM_CLS; k++) begin
      acc_r = acc_r + ACC_W'(pr_r[k]);
      acc_g = acc_g + ACC_W'(pg_r[k]);
      acc_b = acc_b + ACC_W'(pb_r[k]);
    end
    acc_r = acc_r >> COEF_FRAC_BITS;
    acc_g = acc_g >> COEF_FRAC_BITS;
    acc_b = acc_b >> COEF_FRAC_BITS;
    sat_r = (acc_r > ACC_W'(255)) ? CH_W'(255) : acc_r[CH_W-1:0];
    sat_g = (acc_g > ACC_W'(255)) ? CH_W'(255) : acc_g[CH_W-1:0];
    sat_b = (acc_b > ACC_W'(255)) ? CH_W'(255) : acc_b[CH_W-1:0];
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) b1_v_r  <= pop;
      if (adv2) out_v_r <= b1_v_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv1) begin
      pr_r      <= pr_nxt;
      pg_r      <= pg_nxt;
      pb_r      <= pb_nxt;
      b1_row_r  <= head.center_row;
      b1_col_r  <= head.center_col;
      b1_done_r <= head.frame_done;
    end
    if (adv2) begin
      red_r   <= sat_r;
      green_r <= sat_g;
      blue_r  <= sat_b;
      row_r   <= b1_row_r;
      col_r   <= b1_col_r;
      done_r  <= b1_done_r;
    end
  end

  assign out_res.valid      = out_v_r;
  assign out_res.red_out    = red_r;
  assign out_res.green_out  = green_r;
  assign out_res.blue_out   = blue_r;
  assign out_res.center_row = row_r;
  assign out_res.center_col = col_r;
  assign out_res.frame_done = done_r;

endmodule

[rtl/core/gaussian_blur_5x5_rgb_top.sv]
// 5x5 gaussian blur (sigma 1) on an rgb raster stream, top level
// Pixels enter on in_pix in raster order, one beat per pixel; frame_start
// marks column 0 of row 0. Results leave on out_res only for centers at
// least two pixels from every edge, with their row, column and a
// frame_done flag on the last one of the frame. Both channels are
// valid/ready; a beat moves when both are high.
// Throughput is one pixel per cycle while the queue has room. A result is
// set off by the pixel two rows below and two columns right of its center.
// The front (counters, line memory, window) runs without stalling once a
// pixel is taken; an eight-entry queue of class sums feeds the back end
// (multiply, accumulate, output register), so a stalled receiver lets a
// few more pixels in before in_pix.ready drops.
// cfg_we writes image_width (index 0) or image_height (index 1) at once;
// write only while the block is idle. Sizes are clamped to 5..MAX.
// After reset the line memory is cleared, one column a cycle, over all
// MAX_WIDTH columns; in_pix.ready stays low until that pass ends.
`timescale 1ns / 1ps
module gaussian_blur_5x5_rgb_top import glb_pkg::*; #(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  glb_in_if.sink               in_pix,
  glb_out_if.source            out_res
);

  queue_stat_t qstat;
  job_t        push_job, head;
  logic        push, pop, clearing;

  // front end
  glb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .qstat     (qstat),
    .push      (push),
    .push_job  (push_job),
    .clearing  (clearing)
  );

  // queue
  glb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (head),
    .stat     (qstat)
  );

  // back end
  glb_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .qstat   (qstat),
    .head    (head),
    .pop     (pop),
    .out_res (out_res)
  );

`ifndef SYNTHESIS
  // credit scheme keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full && !pop)) else $error("queue overflow");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("queue underflow");

  // no pixel taken while the line memory is cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_pix.ready) else $error("pixel taken during clear");

  // reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> clearing) else $error("clear pass not started");
`endif

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the 5x5 rgb gaussian blur top level
`timescale 1ns / 1ps
module testbench;
  import glb_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        done;
  } blur_res_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fs;
    bit         typed;
    blur_res_t  want;
  } pix_row_t;

  localparam int WMAX = 1024;
  localparam int HMAX = 4096;

  // q0.16 kernel weights by row / column distance from the center
  localparam int unsigned KERNEL_Q16 [3][3] = '{
    '{10624, 6443, 1438},
    '{6443,  3908, 872},
    '{1438,  872,  195}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  glb_in_if  pix_if ();
  glb_out_if res_if ();

  gaussian_blur_5x5_rgb_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_if),
    .out_res   (res_if)
  );

  always #1 clk = ~clk;

  // shadow of the block state
  logic [23:0] line_mem [4][WMAX];
  logic [23:0] win [5][5];
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned img_w;
  int unsigned img_h;

  blur_res_t pending_q [$];
  int errors = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int frames_done = 0;
  int src_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  pix_row_t dir_tab [25];

  // one channel of the kernel over the shadow window
  function automatic logic [7:0] blur_channel(input int sh);
    longint unsigned acc;
    int ay;
    int ax;
    acc = 0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) begin
        ay = (i >= 2) ? i - 2 : 2 - i;
        ax = (j >= 2) ? j - 2 : 2 - j;
        acc += longint'(KERNEL_Q16[ay][ax]) * ((win[i][j] >> sh) & 24'hff);
      end
    acc = acc >> 16;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  // advance the shadow by one pixel, return whether a result comes out
  function automatic bit blur_pixel(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input logic fs,
                                    output blur_res_t res);
    int unsigned w;
    int unsigned h;
    int unsigned rr;
    int unsigned cc;
    logic [23:0] col [5];
    bit got;
    w = (img_w < 5) ? 5 : (img_w > WMAX ? WMAX : img_w);
    h = (img_h < 5) ? 5 : (img_h > HMAX ? HMAX : img_h);
    got = 0;
    res = '0;
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    rr = row_pos;
    cc = col_pos;
    col[0] = line_mem[3][cc];
    col[1] = line_mem[2][cc];
    col[2] = line_mem[1][cc];
    col[3] = line_mem[0][cc];
    col[4] = {r, g, b};
    line_mem[3][cc] = col[1];
    line_mem[2][cc] = col[2];
    line_mem[1][cc] = col[3];
    line_mem[0][cc] = col[4];
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j + 1];
      win[i][4] = col[i];
    end
    if (rr >= 4 && cc >= 4) begin
      res.red   = blur_channel(16);
      res.green = blur_channel(8);
      res.blue  = blur_channel(0);
      res.row   = 12'(rr - 2);
      res.col   = 10'(cc - 2);
      res.done  = (rr == h - 1 && cc == w - 1);
      got = 1;
    end
    col_pos = cc + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = rr + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return got;
  endfunction

  // offer one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fs, input bit typed, input blur_res_t want);
    blur_res_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      pix_if.valid <= 1'b0;
    end
    @(negedge clk);
    pix_if.valid       <= 1'b1;
    pix_if.red_in      <= r;
    pix_if.green_in    <= g;
    pix_if.blue_in     <= b;
    pix_if.frame_start <= fs;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pixels_sent++;
    if (blur_pixel(r, g, b, fs, res)) pending_q.push_back(typed ? want : res);
  endtask

  // let the block drain, then write both size registers
  task automatic set_size(input int w, input int h);
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= CFG_W'(w);
    img_w = w & 'h7ff;
    @(negedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    img_h = h & 'h1fff;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random frames, mostly well formed, with stray frame starts as noise
  task automatic run_frames(input int w, input int h, input int n, input bit lead_fs,
                            input bit press);
    int unsigned area;
    logic [7:0] ch [3];
    logic fs;
    area = ((w < 5) ? 5 : (w > WMAX ? WMAX : w)) * ((h < 5) ? 5 : (h > HMAX ? HMAX : h));
    for (int k = 0; k < n; k++) begin
      for (int c = 0; c < 3; c++)
        case ($urandom_range(9))
          0:       ch[c] = 8'h00;
          1:       ch[c] = 8'hff;
          default: ch[c] = 8'($urandom);
        endcase
      fs = (k % area == 0) ? (k != 0 || lead_fs) : ($urandom_range(99) < 2);
      if (press && k == 20) hold_seq++;
      send_pixel(ch[0], ch[1], ch[2], fs, 1'b0, '0);
    end
  endtask

  // receiver: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left <= 400;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // compare each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      blur_res_t got;
      blur_res_t want;
      got = '{res_if.red_out, res_if.green_out, res_if.blue_out,
              res_if.center_row, res_if.center_col, res_if.frame_done};
      results_seen++;
      if (got.done) frames_done++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result rgb %0d %0d %0d row %0d col %0d done %0d",
                 $time, got.red, got.green, got.blue, got.row, got.col, got.done);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t mismatch exp rgb %0d %0d %0d row %0d col %0d done %0d",
                   $time, want.red, want.green, want.blue, want.row, want.col, want.done);
          $display("%0t          got rgb %0d %0d %0d row %0d col %0d done %0d",
                   $time, got.red, got.green, got.blue, got.row, got.col, got.done);
        end
      end
    end
  end

  // overall time limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    pix_if.valid       = 1'b0;
    pix_if.red_in      = '0;
    pix_if.green_in    = '0;
    pix_if.blue_in     = '0;
    pix_if.frame_start = 1'b0;
    res_if.ready       = 1'b0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < WMAX; j++) line_mem[i][j] = '0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) win[i][j] = '0;
    row_pos = 0;
    col_pos = 0;
    img_w = 640;
    img_h = 480;

    // directed frame: 5x5 white image, single full-scale result at the center
    for (int k = 0; k < 25; k++) begin
      dir_tab[k] = '{8'hff, 8'hff, 8'hff, (k == 0), 1'b0, '0};
    end
    dir_tab[24].typed = 1'b1;
    dir_tab[24].want  = '{8'd255, 8'd255, 8'd255, 12'd2, 10'd2, 1'b1};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    set_size(5, 5);
    foreach (dir_tab[k])
      send_pixel(dir_tab[k].red, dir_tab[k].green, dir_tab[k].blue, dir_tab[k].fs,
                 dir_tab[k].typed, dir_tab[k].want);

    // random phases across sizes and handshake pressure
    run_frames(5, 5, 100, 1, 0);
    src_idle_pct = 51;
    set_size(8, 6);
    run_frames(8, 6, 150, 1, 0);
    src_idle_pct = 0;
    rcv_stall_pct = 51;
    set_size(12, 7);
    run_frames(12, 7, 200, 1, 1);
    src_idle_pct = 28;
    rcv_stall_pct = 28;
    set_size(6, 9);
    run_frames(6, 9, 150, 0, 0);
    // sizes below the minimum clamp to 5
    set_size(0, 0);
    run_frames(0, 0, 80, 1, 0);
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    // widest row, out of range width clamps to the maximum
    set_size(2047, 5);
    run_frames(2047, 5, 60, 1, 0);
    // tallest frame, narrow rows
    set_size(5, 8191);
    run_frames(5, 8191, 100, 1, 0);
    src_idle_pct = 28;
    rcv_stall_pct = 28;
    set_size(9, 7);
    run_frames(9, 7, 150, 1, 0);

    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d pixels, %0d results checked, %0d frame ends seen",
             pixels_sent, results_seen, frames_done);
    $display("small frames, sizes out of range at both ends, stalls on both sides");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
